@@ rtl/core/grc_pkg.sv @@
package grc_pkg;

	localparam int MAP_AW    = 12;
	localparam int CELL_W    = 4;
	localparam int REG_W     = 7;
	localparam int DIV_NUM_W = 35;
	localparam int DIV_DEN_W = 55;
	localparam int TRAVEL_W  = 52;
	localparam int STEP_W    = 41;
	localparam int SLOPE_W   = 27;
	localparam int T_W       = 24;
	localparam int CRD_W     = 9;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;

	localparam logic [17:0] TRAVEL_MAX = 18'h3FFFF;

	typedef struct packed {
		logic               operation;
		logic [11:0]        cell_index;
		logic [3:0]         cell_value;
		logic [15:0]        pos_x;
		logic [15:0]        pos_y;
		logic signed [15:0] dir_cos;
		logic signed [15:0] dir_sin;
		logic [7:0]         column;
	} grc_in_t;

	typedef struct packed {
		logic [3:0]  wall_color;
		logic        wall_horizontal;
		logic [17:0] travel;
		logic [8:0]  column_height;
	} grc_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} grc_div_sts_t;

endpackage

@@ rtl/core/grc_ram.sv @@
module grc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/grc_div.sv @@
module grc_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 55
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      num,
	input  logic [DEN_W-1:0]      den,
	output grc_pkg::grc_div_sts_t sts,
	output logic [NUM_W-1:0]      quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] shifted;
	logic           fits;

	// one quotient bit per cycle, restoring
	always_comb begin
		shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		fits    = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = quo_q;

endmodule

@@ rtl/core/grid_ray_column_caster.sv @@
// channel  direction  payload     handshake
// in       input      grc_in_t    in_valid / in_stall
// out      output     grc_out_t   out_valid / out_stall
// cfg      input      7-bit data  cfg_write / cfg_index
//
// a map write is taken while idle; a cast uses the shared one-bit-per-cycle divider for
// up to four divisions (column slope, two step lengths, column height) and reads the map
// in each grid step
// reset clears the control state and sets both map sides to 64; map contents stay undefined
// the result waits in an output register, so a stalled result does not block the next input

module grid_ray_column_caster #(
	parameter int MAX_MAP_SIDE = 64,
	parameter int RAYS_WIDE    = 240,
	parameter int MAX_STEPS    = 100,
	parameter int HALF_HEIGHT  = 320
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  grc_pkg::grc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output grc_pkg::grc_out_t out_data,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [6:0]        cfg_data
);

	localparam int NW = grc_pkg::DIV_NUM_W;
	localparam int DW = grc_pkg::DIV_DEN_W;
	localparam int TW = grc_pkg::TRAVEL_W;
	localparam int SW = grc_pkg::STEP_W;
	localparam int LW = grc_pkg::SLOPE_W;
	localparam int QW = grc_pkg::T_W;
	localparam int CW = grc_pkg::CRD_W;
	localparam int SC_W = $clog2(MAX_STEPS + 1);
	localparam int SIDE_CAP = (MAX_MAP_SIDE > 127) ? 127 : MAX_MAP_SIDE;
	localparam int HMAX_I = (HALF_HEIGHT > 511) ? 511 : HALF_HEIGHT;
	localparam logic [63:0] HNUM64 = 64'(HALF_HEIGHT) * 64'd3 * (64'd1 << 20);
	localparam logic [NW-1:0] HNUM = HNUM64[NW-1:0];
	localparam logic [NW-1:0] STEP_NUM = {1'b1, {(NW-1){1'b0}}};
	localparam logic [SW-1:0] ZERO_STEP = {1'b1, {(SW-1){1'b0}}};
	localparam logic [8:0] HMAX = 9'(HMAX_I);
	localparam logic signed [12:0] HALF_COLS = 13'(RAYS_WIDE / 2);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_TDIV    = 12'b000000000010,
		S_MUL     = 12'b000000000100,
		S_SLOPE   = 12'b000000001000,
		S_XDIV    = 12'b000000010000,
		S_YDIV    = 12'b000000100000,
		S_INIT_LO = 12'b000001000000,
		S_INIT_HI = 12'b000010000000,
		S_STEP    = 12'b000100000000,
		S_READ    = 12'b001000000000,
		S_HSET    = 12'b010000000000,
		S_HDIV    = 12'b100000000000
	} state_t;

	state_t state_q;
	logic   out_pend_q;

	logic [6:0] map_width_q;
	logic [6:0] map_height_q;
	logic [6:0] w_side;
	logic [6:0] h_side;

	grc_pkg::grc_in_t cast_q;
	logic              t_neg_q;
	logic signed [QW-1:0] t_q;
	logic signed [39:0] prod_s_q;
	logic signed [39:0] prod_c_q;
	logic signed [LW-1:0] sx_q;
	logic signed [LW-1:0] sy_q;
	logic [SW-1:0] dx_q;
	logic [SW-1:0] dy_q;
	logic [31:0] lo_x_q;
	logic [31:0] lo_y_q;
	logic [TW-1:0] tv_q;
	logic [TW-1:0] th_q;
	logic [TW-1:0] travel_q;
	logic signed [CW-1:0] bx_q;
	logic signed [CW-1:0] by_q;
	logic [SC_W-1:0] steps_q;
	logic horiz_q;
	logic [3:0] code_q;
	logic [8:0] height_q;

	logic          div_start_q;
	logic [NW-1:0] div_num_q;
	logic [DW-1:0] div_den_q;
	grc_pkg::grc_div_sts_t div_sts;
	logic [NW-1:0] div_quot;

	logic          ram_wr;
	logic          ram_rd;
	logic [11:0]   ram_addr;
	logic [3:0]    ram_data;

	grc_pkg::grc_out_t out_q;
	logic out_valid_q;
	logic out_load;

	// combinational helpers
	logic signed [12:0] col_diff;
	logic [10:0]        col_abs;
	logic signed [39:0] rnd_s;
	logic signed [39:0] rnd_c;
	logic signed [39:0] sx_w;
	logic signed [39:0] sy_w;
	logic [LW-1:0]      sx_abs;
	logic [LW-1:0]      sy_abs;
	logic               sx_pos;
	logic               sy_pos;
	logic [10:0]        fx;
	logic [10:0]        fy;
	logic [52:0]        sum_x;
	logic [52:0]        sum_y;
	logic               step_h;
	logic signed [CW-1:0] bx_n;
	logic signed [CW-1:0] by_n;
	logic               off_map;
	logic [14:0]        addr_full;

	always_comb begin
		w_side = (map_width_q > 7'(SIDE_CAP)) ? 7'(SIDE_CAP) : map_width_q;
		h_side = (map_height_q > 7'(SIDE_CAP)) ? 7'(SIDE_CAP) : map_height_q;

		col_diff = $signed({5'b0, in_data.column}) - HALF_COLS;
		col_abs  = col_diff[12] ? 11'(-col_diff) : col_diff[10:0];

		// truncation toward zero of the q14 products
		rnd_s = (prod_s_q + (prod_s_q[39] ? 40'sd16383 : 40'sd0)) >>> 14;
		rnd_c = (prod_c_q + (prod_c_q[39] ? 40'sd16383 : 40'sd0)) >>> 14;
		sx_w  = 40'($signed(cast_q.dir_cos)) - rnd_s;
		sy_w  = 40'($signed(cast_q.dir_sin)) + rnd_c;
		sx_abs = sx_w[39] ? LW'(-sx_w) : sx_w[LW-1:0];
		sy_abs = sy_q[LW-1] ? LW'(-sy_q) : sy_q;

		sx_pos = !sx_q[LW-1] && (sx_q != '0);
		sy_pos = !sy_q[LW-1] && (sy_q != '0);
		fx = sx_pos ? (11'd1024 - {1'b0, cast_q.pos_x[9:0]}) : {1'b0, cast_q.pos_x[9:0]};
		fy = sy_pos ? (11'd1024 - {1'b0, cast_q.pos_y[9:0]}) : {1'b0, cast_q.pos_y[9:0]};
		sum_x = (53'(fx * dx_q[SW-1:21]) << 21) + 53'(lo_x_q);
		sum_y = (53'(fy * dy_q[SW-1:21]) << 21) + 53'(lo_y_q);

		step_h = th_q < tv_q;
		bx_n = bx_q;
		by_n = by_q;
		if (step_h) begin
			by_n = by_q + (sy_pos ? CW'(1) : -CW'(1));
		end else begin
			bx_n = bx_q + (sx_pos ? CW'(1) : -CW'(1));
		end
		off_map = bx_n[CW-1] || by_n[CW-1] ||
			(bx_n >= $signed({2'b0, w_side})) || (by_n >= $signed({2'b0, h_side}));
		addr_full = 15'(bx_n[7:0]) + 15'(by_n[7:0]) * 15'(w_side);

		ram_wr = (state_q == S_IDLE) && in_valid && (in_data.operation == grc_pkg::OP_WRITE);
		ram_rd = (state_q == S_STEP) && !off_map;
		ram_addr = ram_wr ? in_data.cell_index : addr_full[11:0];

		out_load = out_pend_q && (!out_valid_q || !out_stall);
	end

	grc_ram #(
		.WIDTH(grc_pkg::CELL_W),
		.DEPTH(1 << grc_pkg::MAP_AW)
	) u_map (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(in_data.cell_index),
		.wr_data(in_data.cell_value),
		.rd_en  (ram_rd),
		.rd_addr(addr_full[11:0]),
		.rd_data(ram_data)
	);

	grc_div #(
		.NUM_W(NW),
		.DEN_W(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (div_num_q),
		.den   (div_den_q),
		.sts   (div_sts),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			map_width_q  <= 7'd64;
			map_height_q <= 7'd64;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_pend_q   <= 1'b0;
			steps_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (cfg_write) begin
				case (cfg_index)
					grc_pkg::REG_MAP_WIDTH:  map_width_q <= cfg_data;
					grc_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_pend_q  <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && !out_pend_q && in_data.operation == grc_pkg::OP_CAST) begin
						div_start_q <= 1'b1;
						state_q     <= S_TDIV;
					end
				end
				S_TDIV: if (div_sts.done) state_q <= S_MUL;
				S_MUL: state_q <= S_SLOPE;
				S_SLOPE: begin
					div_start_q <= 1'b1;
					state_q     <= S_XDIV;
				end
				S_XDIV: begin
					if (div_sts.done) begin
						div_start_q <= 1'b1;
						state_q     <= S_YDIV;
					end
				end
				S_YDIV: if (div_sts.done) state_q <= S_INIT_LO;
				S_INIT_LO: state_q <= S_INIT_HI;
				S_INIT_HI: begin
					steps_q <= '0;
					state_q <= S_STEP;
				end
				S_STEP: begin
					steps_q <= steps_q + SC_W'(1);
					state_q <= off_map ? S_HSET : S_READ;
				end
				S_READ: begin
					if (steps_q < SC_W'(MAX_STEPS) && ram_data == '0) begin
						state_q <= S_STEP;
					end else begin
						state_q <= S_HSET;
					end
				end
				S_HSET: begin
					if (travel_q == '0) begin
						out_pend_q <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= S_HDIV;
					end
				end
				S_HDIV: begin
					if (div_sts.done) begin
						out_pend_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cast_q    <= in_data;
				t_neg_q   <= col_diff[12];
				div_num_q <= NW'({col_abs, 15'b0});
				div_den_q <= DW'(RAYS_WIDE);
			end
			S_TDIV: begin
				t_q <= t_neg_q ? (QW'(0) - div_quot[QW-1:0]) : div_quot[QW-1:0];
			end
			S_MUL: begin
				prod_s_q <= t_q * cast_q.dir_sin;
				prod_c_q <= t_q * cast_q.dir_cos;
			end
			S_SLOPE: begin
				sx_q      <= sx_w[LW-1:0];
				sy_q      <= sy_w[LW-1:0];
				div_num_q <= STEP_NUM;
				div_den_q <= DW'(sx_abs);
			end
			S_XDIV: begin
				if (div_sts.done) begin
					dx_q      <= (sx_q == '0) ? ZERO_STEP : SW'(div_quot);
					div_den_q <= DW'(sy_abs);
				end
			end
			S_YDIV: begin
				if (div_sts.done) begin
					dy_q <= (sy_q == '0) ? ZERO_STEP : SW'(div_quot);
				end
			end
			S_INIT_LO: begin
				lo_x_q <= 32'(fx * dx_q[20:0]);
				lo_y_q <= 32'(fy * dy_q[20:0]);
				bx_q   <= CW'(cast_q.pos_x[15:10]);
				by_q   <= CW'(cast_q.pos_y[15:10]);
			end
			S_INIT_HI: begin
				tv_q     <= TW'(sum_x[52:10]);
				th_q     <= TW'(sum_y[52:10]);
				travel_q <= '0;
				horiz_q  <= 1'b0;
				code_q   <= '0;
			end
			S_STEP: begin
				horiz_q <= step_h;
				bx_q    <= bx_n;
				by_q    <= by_n;
				code_q  <= '0;
				if (step_h) begin
					travel_q <= th_q;
					th_q     <= th_q + TW'(dy_q);
				end else begin
					travel_q <= tv_q;
					tv_q     <= tv_q + TW'(dx_q);
				end
			end
			S_READ: code_q <= ram_data;
			S_HSET: begin
				height_q  <= HMAX;
				div_num_q <= HNUM;
				div_den_q <= DW'({travel_q, 2'b0}) + DW'(travel_q);
			end
			S_HDIV: begin
				if (div_sts.done && div_quot < NW'(HMAX)) begin
					height_q <= div_quot[8:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.wall_color      <= code_q + (horiz_q ? 4'd8 : 4'd0);
			out_q.wall_horizontal <= horiz_q;
			out_q.travel          <= (travel_q[TW-1:10] > (TW-10)'(grc_pkg::TRAVEL_MAX)) ?
				grc_pkg::TRAVEL_MAX : travel_q[27:10];
			out_q.column_height   <= height_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE) || out_pend_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> !div_sts.busy)
		else $error("divider started while busy");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= SC_W'(MAX_STEPS))
		else $error("step count beyond limit");
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd |=> state_q == S_READ)
		else $error("map read without evaluation");
	a_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.column_height <= HMAX)
		else $error("column height beyond cap");

endmodule
